>>> hw/rtl/sfat_pkg.sv
// ----------------------------------------------------------------------------
// sfat_pkg: shared types and constants for the sprite frame animator table
// Holds the slot entry layout, operation and status codes and sequencer states.
// ----------------------------------------------------------------------------
package sfat_pkg;

  localparam int SLOTS_DEF = 128;

  localparam logic [1:0] OP_CREATE = 2'd0;
  localparam logic [1:0] OP_TICK   = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_UNUSED = 2'd2;

  localparam int DIV_W = 10;

  typedef struct packed {
    logic [9:0]  count;
    logic [7:0]  tex;
    logic [9:0]  w;
    logic [9:0]  h;
    logic [9:0]  cols;
    logic [15:0] ft;
    logic        loop;
    logic [9:0]  idx;
    logic [16:0] timer;
    logic [31:0] elapsed;
  } slot_ent_t;

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_SCAN,
    S_TICK,
    S_QRD,
    S_QCHK,
    S_DIV1,
    S_DIV2S,
    S_DIV2,
    S_MX,
    S_MY,
    S_ML,
    S_FIN,
    S_OUT
  } seq_state_t;

endpackage

>>> hw/rtl/sprite_frame_animator_table_unit.sv
// ----------------------------------------------------------------------------
// Create scans the slot memory for the first free slot, tick sweeps every slot,
// query reads one slot and, for a used one, runs the divider and multiplier, and
// clear sweeps every slot; the result then waits in the output register for a
// transfer. One op at a time is in flight; the slot memory port sets tick and
// create cost. Reset: rst is synchronous; afterwards a clearing pass frees every
// slot before the first input transfer is taken.
// ----------------------------------------------------------------------------
// sprite_frame_animator_table_unit: sprite sheet flipbook animation table
// A sequencer walks one slot memory; a shared divider and multiplier serve
// queries.
// ----------------------------------------------------------------------------
module sprite_frame_animator_table_unit import sfat_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  op,
  input  logic [6:0]  slot,
  input  logic [7:0]  texture,
  input  logic [9:0]  frame_width,
  input  logic [9:0]  frame_height,
  input  logic [9:0]  frame_count,
  input  logic [9:0]  columns,
  input  logic [15:0] frame_time,
  input  logic        looping,
  input  logic [15:0] tick_delta,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [6:0]  slot_id,
  output logic [7:0]  texture_out,
  output logic [9:0]  frame_index,
  output logic [19:0] source_x,
  output logic [19:0] source_y,
  output logic [9:0]  width_out,
  output logic [9:0]  height_out,
  output logic        finished
);

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  seq_state_t state, state_next;

  // Captured input item.
  logic [6:0]  slot_r;
  logic [7:0]  tex_r;
  logic [9:0]  w_r, h_r, n_r, cols_r;
  logic [15:0] ft_r, dt_r;
  logic        loop_r;

  // Sweep counter and the address whose read data is now on the memory output.
  logic [SW:0]   cnt;
  logic          pend;
  logic [SW-1:0] pa;
  logic          clr_reply;

  // Memory port controls.
  logic          we;
  logic [SW-1:0] waddr, raddr;
  slot_ent_t     wdata, rdata, qe;

  // Shared divider and multiplier.
  logic             div_start, div_done;
  logic [DIV_W-1:0] div_a, div_b, div_q, div_r;
  logic [9:0]       fq, col, row;
  logic [9:0]       mul_a;
  logic [15:0]      mul_b;
  logic [25:0]      prod;

  logic accept;
  logic sweep_last;
  logic tick_last;
  logic q_oob;

  // Per-slot tick update.
  logic [32:0] esum;
  logic [17:0] tsum;
  logic [16:0] tsat;
  logic        adv;
  logic [10:0] f1, f2, f3, n11;
  slot_ent_t   tick_ent, new_ent;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_OUT);

  assign sweep_last = (32'(cnt) == SLOTS - 1);
  assign tick_last  = pend && (32'(pa) == SLOTS - 1);
  assign q_oob      = (32'(slot_r) >= SLOTS);

  always_comb begin
    esum = {1'b0, rdata.elapsed} + 33'(dt_r);
    tsum = {1'b0, rdata.timer} + 18'(dt_r);
    tsat = tsum[17] ? '1 : tsum[16:0];
    adv  = (tsat >= 17'(rdata.ft));
    n11  = {1'b0, rdata.count};
    f1   = {1'b0, rdata.idx} + 11'd1;
    f2   = (!rdata.loop && (f1 >= n11)) ? (n11 - 11'd1) : f1;
    f3   = (f2 >= n11) ? 11'd0 : f2;
    tick_ent         = rdata;
    tick_ent.elapsed = esum[32] ? '1 : esum[31:0];
    tick_ent.timer   = adv ? '0 : tsat;
    tick_ent.idx     = adv ? f3[9:0] : rdata.idx;
  end

  always_comb begin
    new_ent.count   = n_r;
    new_ent.tex     = tex_r;
    new_ent.w       = w_r;
    new_ent.h       = h_r;
    new_ent.cols    = cols_r;
    new_ent.ft      = ft_r;
    new_ent.loop    = loop_r;
    new_ent.idx     = '0;
    new_ent.timer   = '0;
    new_ent.elapsed = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and memory / divider controls.
  always_comb begin
    state_next = state;
    we         = 1'b0;
    waddr      = pa;
    wdata      = tick_ent;
    raddr      = cnt[SW-1:0];
    div_start  = 1'b0;
    div_a      = qe.idx;
    div_b      = qe.count;
    mul_a      = qe.w;
    mul_b      = 16'(col);
    case (state)
      S_CLR: begin
        we    = 1'b1;
        waddr = cnt[SW-1:0];
        wdata = '0;
        if (sweep_last) state_next = clr_reply ? S_OUT : S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          case (op)
            OP_CREATE: state_next = S_SCAN;
            OP_TICK:   state_next = S_TICK;
            OP_QUERY:  state_next = S_QRD;
            default:   state_next = S_CLR;
          endcase
        end
      end
      S_SCAN: begin
        if (pend && (rdata.count == '0)) begin
          we         = 1'b1;
          wdata      = new_ent;
          state_next = S_OUT;
        end else if (tick_last) begin
          state_next = S_OUT;
        end
      end
      S_TICK: begin
        if (pend && (rdata.count != '0)) we = 1'b1;
        if (tick_last) state_next = S_OUT;
      end
      S_QRD: begin
        raddr      = SW'(slot_r);
        state_next = q_oob ? S_OUT : S_QCHK;
      end
      S_QCHK: begin
        raddr = SW'(slot_r);
        if (rdata.count == '0) begin
          state_next = S_OUT;
        end else begin
          div_start  = 1'b1;
          div_a      = rdata.idx;
          div_b      = rdata.count;
          state_next = S_DIV1;
        end
      end
      S_DIV1: begin
        if (div_done) state_next = (qe.cols == '0) ? S_MX : S_DIV2S;
      end
      S_DIV2S: begin
        div_start  = 1'b1;
        div_a      = fq;
        div_b      = qe.cols;
        state_next = S_DIV2;
      end
      S_DIV2: begin
        if (div_done) state_next = S_MX;
      end
      S_MX: begin
        state_next = S_MY;
      end
      S_MY: begin
        mul_a      = qe.h;
        mul_b      = 16'(row);
        state_next = S_ML;
      end
      S_ML: begin
        mul_a      = qe.count;
        mul_b      = qe.ft;
        state_next = S_FIN;
      end
      S_FIN: begin
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!out_stall) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      pend      <= 1'b0;
      clr_reply <= 1'b0;
    end else begin
      case (state)
        S_CLR: begin
          cnt <= cnt + 1'b1;
        end
        S_IDLE: begin
          cnt       <= '0;
          pend      <= 1'b0;
          clr_reply <= 1'b1;
          if (accept) begin
            slot_r      <= slot;
            tex_r       <= texture;
            w_r         <= frame_width;
            h_r         <= frame_height;
            n_r         <= frame_count;
            cols_r      <= columns;
            ft_r        <= frame_time;
            loop_r      <= looping;
            dt_r        <= tick_delta;
            status      <= ST_OK;
            slot_id     <= '0;
            texture_out <= '0;
            frame_index <= '0;
            source_x    <= '0;
            source_y    <= '0;
            width_out   <= '0;
            height_out  <= '0;
            finished    <= 1'b0;
          end
        end
        S_SCAN, S_TICK: begin
          if (32'(cnt) < SLOTS) begin
            pend <= 1'b1;
            pa   <= cnt[SW-1:0];
            cnt  <= cnt + 1'b1;
          end else begin
            pend <= 1'b0;
          end
          if (state == S_SCAN) begin
            if (pend && (rdata.count == '0)) begin
              slot_id <= 7'(pa);
            end else if (tick_last) begin
              status <= ST_FULL;
            end
          end
        end
        S_QRD: begin
          slot_id <= slot_r;
          if (q_oob) status <= ST_UNUSED;
        end
        S_QCHK: begin
          qe <= rdata;
          if (rdata.count == '0) status <= ST_UNUSED;
        end
        S_DIV1: begin
          if (div_done) begin
            fq  <= div_r;
            col <= div_r;
            row <= '0;
          end
        end
        S_DIV2: begin
          if (div_done) begin
            col <= div_r;
            row <= div_q;
          end
        end
        S_MX: begin
          prod <= 26'(mul_a) * 26'(mul_b);
        end
        S_MY: begin
          source_x <= prod[19:0];
          prod     <= 26'(mul_a) * 26'(mul_b);
        end
        S_ML: begin
          source_y <= prod[19:0];
          prod     <= 26'(mul_a) * 26'(mul_b);
        end
        S_FIN: begin
          finished    <= ({6'd0, prod} <= qe.elapsed);
          texture_out <= qe.tex;
          frame_index <= fq;
          width_out   <= qe.w;
          height_out  <= qe.h;
        end
        default: begin
        end
      endcase
    end
  end

  sfat_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quot     (div_q),
    .rem      (div_r)
  );

  sfat_table #(
    .SLOTS (SLOTS),
    .SW    (SW)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // A result is only presented while the input side is held off.
  a_out_blocks_in: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("result shown while input open");

  // The memory is only written by the clearing pass, create and tick.
  a_write_states: assert property (@(posedge clk) disable iff (rst)
    we |-> (state == S_CLR || state == S_SCAN || state == S_TICK))
    else $error("slot write outside sweep");

  // The divider only finishes while the sequencer waits for it.
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV1 || state == S_DIV2))
    else $error("divider result not awaited");

  // An accepted transfer always leaves the idle state.
  a_accept_leaves: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state != S_IDLE)) else $error("accepted op not started");

endmodule

>>> hw/rtl/sfat_div.sv
// ----------------------------------------------------------------------------
// sfat_div: iterative restoring divider
// Produces quotient and remainder of two 10-bit values, one bit per cycle.
// ----------------------------------------------------------------------------
module sfat_div import sfat_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DIV_W-1:0] divisor,
  output logic             done,
  output logic [DIV_W-1:0] quot,
  output logic [DIV_W-1:0] rem
);

  localparam int CW = $clog2(DIV_W + 1);

  logic [CW-1:0]    cnt;
  logic             busy;
  logic [DIV_W-1:0] dsr;
  logic [DIV_W:0]   shifted;
  logic [DIV_W:0]   trial;

  assign shifted = {rem, quot[DIV_W-1]};
  assign trial   = shifted - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(DIV_W);
        rem  <= '0;
        quot <= dividend;
        dsr  <= divisor;
      end else if (busy) begin
        if (!trial[DIV_W]) begin
          rem  <= trial[DIV_W-1:0];
          quot <= {quot[DIV_W-2:0], 1'b1};
        end else begin
          rem  <= shifted[DIV_W-1:0];
          quot <= {quot[DIV_W-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> hw/rtl/sfat_table.sv
// ----------------------------------------------------------------------------
// sfat_table: slot entry memory
// One write port and one registered read port over all slot entries.
// ----------------------------------------------------------------------------
module sfat_table import sfat_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF,
  parameter int SW    = 7
) (
  input  logic          clk,
  input  logic          we,
  input  logic [SW-1:0] waddr,
  input  slot_ent_t     wdata,
  input  logic [SW-1:0] raddr,
  output slot_ent_t     rdata
);

  slot_ent_t mem [SLOTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
